[hdl/acm_pkg.sv]
// Shared types, constants and AES round functions for the CTR/CBC-MAC engine.
package acm_pkg;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;
	localparam logic [3:0] LAST_ROUND = 4'd10;

	typedef struct packed {
		logic [127:0] data;
		logic [15:0]  byte_mask;
		logic         first_block;
		logic [63:0]  nonce;
		logic [59:0]  start_block;
		logic         encrypt_mode;
	} item_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
		logic [31:0] w0, w1, w2, w3, tmp;
		w0 = rk[127:96];
		w1 = rk[95:64];
		w2 = rk[63:32];
		w3 = rk[31:0];
		tmp = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ tmp;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
			input logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] o;
		for (int i = 0; i < 16; i++) begin
			b[i] = s[127-8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				t[j+4*c] = SBOX[b[j + 4*((c+j) & 3)]];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c];
				a1 = t[4*c+1];
				a2 = t[4*c+2];
				a3 = t[4*c+3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			o[127-8*i -: 8] = t[i] ^ rk[127-8*i -: 8];
		end
		return o;
	endfunction

endpackage

[hdl/acm_front.sv]
// Front end: accepts requests, builds the MAC byte mask and queues them.
module acm_front import acm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [63:0]  data_high,
	input  logic [63:0]  data_low,
	input  logic [4:0]   valid_bytes,
	input  logic         first_block,
	input  logic [63:0]  nonce,
	input  logic [59:0]  start_block,
	input  logic         encrypt_mode,
	output logic         avail,
	output item_t        head,
	input  logic         take
);

	item_t      slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	item_t      item;
	logic       do_push, do_take;

	always_comb begin
		item.data = {data_high, data_low};
		for (int i = 0; i < 16; i++) begin
			item.byte_mask[i] = (valid_bytes > 5'(i));
		end
		item.first_block  = first_block;
		item.nonce        = nonce;
		item.start_block  = start_block;
		item.encrypt_mode = encrypt_mode;
	end

	assign full    = (count_q == 2'd2);
	assign avail   = (count_q != 2'd0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_take = take && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_take};
		end
	end

endmodule

[hdl/acm_aes.sv]
// Iterative AES-128 encryption unit with on-the-fly key expansion.
module acm_aes import acm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] block_in,
	input  logic [127:0] key,
	output logic         busy,
	output logic         done,
	output logic [127:0] block_out
);

	logic [127:0] state_q, rk_q, rk_n;
	logic [7:0]   rcon_q;
	logic [3:0]   round_q;
	logic         busy_q, done_q;

	assign rk_n      = key_next(rk_q, rcon_q);
	assign busy      = busy_q;
	assign done      = done_q;
	assign block_out = state_q;

	always_ff @(posedge clk) begin
		if (start) begin
			state_q <= block_in ^ key;
			rk_q    <= key;
			rcon_q  <= 8'h01;
		end else if (busy_q) begin
			state_q <= aes_round(state_q, rk_n, round_q == LAST_ROUND);
			rk_q    <= rk_n;
			rcon_q  <= xtime(rcon_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			round_q <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				round_q <= 4'd1;
			end else if (busy_q) begin
				if (round_q == LAST_ROUND) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					round_q <= round_q + 4'd1;
				end
			end
		end
	end

endmodule

[hdl/acm_back.sv]
// Back end: key registers, counter and MAC chaining, and the result register.
module acm_back import acm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 avail,
	input  item_t                head,
	output logic                 take,
	output logic                 empty,
	input  logic                 pop,
	output logic [63:0]          result_high,
	output logic [63:0]          result_low,
	output logic [63:0]          tag_high,
	output logic [63:0]          tag_low
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_KS   = 2'd1;
	localparam logic [1:0] ST_MAC  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]   state_q;
	logic [63:0]  key_high_q, key_low_q;
	logic [127:0] counter_q, mac_q, data_q, result_q, mask_q;
	logic         enc_q;
	logic [127:0] out_result_q, out_tag_q;
	logic         out_valid_q;

	logic         core_start, core_busy, core_done;
	logic [127:0] core_in, core_out;
	logic [127:0] ctr_sel, mac_sel, ks_result, plain, mask128;
	logic         slot_free;

	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || pop;
	assign take      = (state_q == ST_IDLE) && avail;
	assign empty     = !out_valid_q;
	assign result_high = out_result_q[127:64];
	assign result_low  = out_result_q[63:0];
	assign tag_high    = out_tag_q[127:64];
	assign tag_low     = out_tag_q[63:0];

	always_comb begin
		ctr_sel = head.first_block ? {head.nonce, 4'b0, head.start_block} : counter_q;
		mac_sel = head.first_block ? {head.nonce, head.nonce} : mac_q;
		for (int i = 0; i < 16; i++) begin
			mask128[127-8*i -: 8] = {8{head.byte_mask[i]}};
		end
		ks_result  = data_q ^ core_out;
		plain      = enc_q ? data_q : ks_result;
		core_start = take || ((state_q == ST_KS) && core_done);
		core_in    = take ? ctr_sel : (mac_q ^ (plain & mask_q));
	end

	acm_aes u_aes (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (core_start),
		.block_in  (core_in),
		.key       ({key_high_q, key_low_q}),
		.busy      (core_busy),
		.done      (core_done),
		.block_out (core_out)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			data_q    <= head.data;
			mask_q    <= mask128;
			enc_q     <= head.encrypt_mode;
		end
		if ((state_q == ST_KS) && core_done) begin
			result_q <= ks_result;
		end
		if (((state_q == ST_MAC) && core_done && slot_free) ||
				((state_q == ST_OUT) && slot_free)) begin
			out_result_q <= result_q;
			out_tag_q    <= (state_q == ST_MAC) ? core_out : mac_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_high_q  <= 64'd0;
			key_low_q   <= 64'd0;
			counter_q   <= 128'd0;
			mac_q       <= 128'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_KEY_HIGH) begin
					key_high_q <= cfg_data;
				end
				if (cfg_index == REG_KEY_LOW) begin
					key_low_q <= cfg_data;
				end
			end
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						counter_q <= ctr_sel + 128'd1;
						mac_q     <= mac_sel;
						state_q   <= ST_KS;
					end
				end
				ST_KS: begin
					if (core_done) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (core_done) begin
						mac_q <= core_out;
						if (slot_free) begin
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		core_start |-> !core_busy)
		else $error("AES unit started while busy.");
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |-> (state_q == ST_KS || state_q == ST_MAC))
		else $error("AES unit finished outside a pass.");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_MAC || $past(state_q) == ST_OUT))
		else $error("Result appeared without a finished MAC pass.");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> out_valid_q)
		else $error("Finished result waits while the output register is free.");

endmodule

[hdl/aes_ctr_cbc_mac_block.sv]
// Top level of the AES-128 counter-mode engine with running CBC-MAC.
//  channel  | handshake           | payload
//  input    | push / full         | data_high, data_low, valid_bytes, first_block,
//           |                     | nonce, start_block, encrypt_mode
//  result   | empty / pop         | result_high, result_low, tag_high, tag_low
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
// In the back end one shared iterative AES unit runs a keystream pass and then a MAC pass
// for each request; a new request is taken only from idle, once the last result is registered.
// A two-entry request queue and one result register let input and output stall
// independently. Reset clears the key, counter and MAC and empties the queue and result register.
module aes_ctr_cbc_mac_block import acm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [63:0]          data_high,
	input  logic [63:0]          data_low,
	input  logic [4:0]           valid_bytes,
	input  logic                 first_block,
	input  logic [63:0]          nonce,
	input  logic [59:0]          start_block,
	input  logic                 encrypt_mode,
	output logic                 empty,
	input  logic                 pop,
	output logic [63:0]          result_high,
	output logic [63:0]          result_low,
	output logic [63:0]          tag_high,
	output logic [63:0]          tag_low,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	logic  avail, take;
	item_t head;

	acm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_high    (data_high),
		.data_low     (data_low),
		.valid_bytes  (valid_bytes),
		.first_block  (first_block),
		.nonce        (nonce),
		.start_block  (start_block),
		.encrypt_mode (encrypt_mode),
		.avail        (avail),
		.head         (head),
		.take         (take)
	);

	acm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.avail       (avail),
		.head        (head),
		.take        (take),
		.empty       (empty),
		.pop         (pop),
		.result_high (result_high),
		.result_low  (result_low),
		.tag_high    (tag_high),
		.tag_low     (tag_low)
	);

endmodule

[tb/aes_ctr_cbc_mac_block_test.sv]
// Testbench for the AES-128 counter-mode engine with running CBC-MAC, checked against a predictor.
`timescale 1ns / 100ps
module aes_ctr_cbc_mac_block_test;
	import acm_pkg::*;

	typedef struct packed {
		logic [63:0] d_hi;
		logic [63:0] d_lo;
		logic [4:0]  vb;
		logic        first;
		logic [63:0] nonce;
		logic [59:0] start;
		logic        enc;
	} block_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [63:0] data_high = '0;
	logic [63:0] data_low = '0;
	logic [4:0] valid_bytes = 5'd16;
	logic first_block = 1'b0;
	logic [63:0] nonce = '0;
	logic [59:0] start_block = '0;
	logic encrypt_mode = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [63:0] result_high, result_low, tag_high, tag_low;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_HIGH;
	logic [63:0] cfg_data = '0;

	logic [127:0] key_q = '0;
	logic [127:0] ctr_q = '0;
	logic [127:0] mac_q = '0;
	logic [255:0] expected_blocks [$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_req = 0;
	int hold_cnt = 0;
	int msg_left = 0;
	logic msg_enc = 1'b1;

	block_req_t dir_rows [22] = '{
		'{64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 1'b0, 64'h0, 60'h0, 1'b1},
		'{64'h0, 64'h0, 5'd16, 1'b1, 64'h0, 60'h0, 1'b1},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b0, 64'h0, 60'h0, 1'b1},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b1,
			64'hffffffffffffffff, 60'hfffffffffffffff, 1'b1},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd1, 1'b0, 64'h0, 60'h0, 1'b1},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd7, 1'b0, 64'h0, 60'h0, 1'b1},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd8, 1'b0, 64'h0, 60'h0, 1'b1},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd9, 1'b0, 64'h0, 60'h0, 1'b1},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd15, 1'b0, 64'h0, 60'h0, 1'b1},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd0, 1'b0, 64'h0, 60'h0, 1'b1},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd17, 1'b0, 64'h0, 60'h0, 1'b1},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd31, 1'b0, 64'h0, 60'h0, 1'b1},
		'{64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5, 5'd16, 1'b1,
			64'h1122334455667788, 60'h123456789abcdef, 1'b0},
		'{64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5, 5'd16, 1'b0, 64'h0, 60'h0, 1'b0},
		'{64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5, 5'd3, 1'b0, 64'h0, 60'h0, 1'b0},
		'{64'h0, 64'h0, 5'd0, 1'b0, 64'h0, 60'h0, 1'b0},
		'{64'hffffffffffffffff, 64'h0, 5'd12, 1'b1, 64'h0, 60'hfffffffffffffff, 1'b0},
		'{64'h0, 64'hffffffffffffffff, 5'd16, 1'b1, 64'hffffffffffffffff, 60'h0, 1'b1},
		'{64'h8000000000000001, 64'h8000000000000001, 5'd16, 1'b0, 64'h0, 60'h0, 1'b1},
		'{64'hdeadbeefdeadbeef, 64'hcafef00dcafef00d, 5'd16, 1'b1,
			64'h0f0f0f0f0f0f0f0f, 60'h0f0f0f0f0f0f0f0, 1'b0},
		'{64'hdeadbeefdeadbeef, 64'hcafef00dcafef00d, 5'd31, 1'b0, 64'h0, 60'h0, 1'b0},
		'{64'h0, 64'h0, 5'd16, 1'b0, 64'h0, 60'h0, 1'b1}
	};

	aes_ctr_cbc_mac_block i_dut (
		.clk, .arst_n, .push, .full, .data_high, .data_low, .valid_bytes, .first_block,
		.nonce, .start_block, .encrypt_mode, .empty, .pop, .result_high, .result_low,
		.tag_high, .tag_low, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] gf_mul2(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] aes128_encrypt(input logic [127:0] pt, input logic [127:0] k);
		logic [127:0] rk, st;
		logic [7:0] rc, a0, a1, a2, a3, all;
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [31:0] w;
		rk = k;
		st = pt ^ k;
		rc = 8'h01;
		for (int r = 1; r <= 10; r++) begin
			w = rk[31:0];
			w = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
			rk[127:96] = rk[127:96] ^ w;
			rk[95:64] = rk[95:64] ^ rk[127:96];
			rk[63:32] = rk[63:32] ^ rk[95:64];
			rk[31:0] = rk[31:0] ^ rk[63:32];
			rc = gf_mul2(rc);
			for (int i = 0; i < 16; i++) begin
				b[i] = st[127-8*i -: 8];
			end
			for (int c = 0; c < 4; c++) begin
				for (int j = 0; j < 4; j++) begin
					t[j+4*c] = SBOX[b[j + 4*((c+j) & 3)]];
				end
			end
			if (r != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c];
					a1 = t[4*c+1];
					a2 = t[4*c+2];
					a3 = t[4*c+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					t[4*c] = a0 ^ all ^ gf_mul2(a0 ^ a1);
					t[4*c+1] = a1 ^ all ^ gf_mul2(a1 ^ a2);
					t[4*c+2] = a2 ^ all ^ gf_mul2(a2 ^ a3);
					t[4*c+3] = a3 ^ all ^ gf_mul2(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) begin
				st[127-8*i -: 8] = t[i] ^ rk[127-8*i -: 8];
			end
		end
		return st;
	endfunction

	function automatic logic [255:0] predict_block(input block_req_t rq);
		logic [127:0] ks, res, plain, mask;
		int n;
		n = (rq.vb > 16) ? 16 : rq.vb;
		if (rq.first) begin
			ctr_q = {rq.nonce, 4'h0, rq.start};
			mac_q = {rq.nonce, rq.nonce};
		end
		ks = aes128_encrypt(ctr_q, key_q);
		res = {rq.d_hi, rq.d_lo} ^ ks;
		plain = rq.enc ? {rq.d_hi, rq.d_lo} : res;
		mask = (n == 0) ? '0 : ({128{1'b1}} << (128 - 8*n));
		mac_q = aes128_encrypt(mac_q ^ (plain & mask), key_q);
		ctr_q = ctr_q + 128'd1;
		return {res, mac_q};
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		logic [255:0] want;
		if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_KEY_HIGH) begin
				key_q[127:64] = cfg_data;
			end else begin
				key_q[63:0] = cfg_data;
			end
		end
		if (push && !full) begin
			expected_blocks.push_back(predict_block({data_high, data_low, valid_bytes,
				first_block, nonce, start_block, encrypt_mode}));
		end
		if (pop && !empty) begin
			if (expected_blocks.size() == 0) begin
				report_mismatch("unexpected result", result_high, 64'h0);
			end else begin
				want = expected_blocks.pop_front();
				if (result_high !== want[255:192]) report_mismatch("result_high", result_high, want[255:192]);
				if (result_low !== want[191:128]) report_mismatch("result_low", result_low, want[191:128]);
				if (tag_high !== want[127:64]) report_mismatch("tag_high", tag_high, want[127:64]);
				if (tag_low !== want[63:0]) report_mismatch("tag_low", tag_low, want[63:0]);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = 400;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send_block(input block_req_t rq);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		data_high <= rq.d_hi;
		data_low <= rq.d_lo;
		valid_bytes <= rq.vb;
		first_block <= rq.first;
		nonce <= rq.nonce;
		start_block <= rq.start;
		encrypt_mode <= rq.enc;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic drain_and_settle();
		@(negedge clk);
		push <= 1'b0;
		while (expected_blocks.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] pick_word();
		case ($urandom_range(9))
			0: return 64'h0;
			1: return {64{1'b1}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_random(input int count);
		block_req_t rq;
		for (int i = 0; i < count; i++) begin
			rq.d_hi = pick_word();
			rq.d_lo = pick_word();
			rq.nonce = pick_word();
			rq.start = 60'(pick_word());
			if (msg_left == 0 && $urandom_range(99) < 85) begin
				msg_left = $urandom_range(6, 1);
				msg_enc = 1'($urandom_range(1));
				rq.first = 1'b1;
			end else begin
				rq.first = 1'b0;
			end
			if (msg_left > 0) begin
				rq.enc = msg_enc;
				rq.vb = (msg_left == 1 && $urandom_range(1)) ? 5'($urandom_range(16, 1)) : 5'd16;
				msg_left--;
			end else begin
				rq.enc = 1'($urandom_range(1));
				rq.first = 1'($urandom_range(1));
				rq.vb = 5'($urandom_range(31));
			end
			send_block(rq);
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		foreach (dir_rows[i]) begin
			send_block(dir_rows[i]);
		end
		drain_and_settle();
		write_key(REG_KEY_HIGH, {64{1'b1}});
		write_key(REG_KEY_LOW, {64{1'b1}});
		send_random(80);
		drain_and_settle();
		// The message left open here continues under the new key.
		write_key(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
		write_key(REG_KEY_LOW, 64'habf7158809cf4f3c);
		send_idle = 85;
		send_random(70);
		drain_and_settle();
		write_key(REG_KEY_LOW, {$urandom, $urandom});
		send_idle = 0;
		recv_stall = 85;
		send_random(80);
		drain_and_settle();
		write_key(REG_KEY_HIGH, 64'h0);
		write_key(REG_KEY_LOW, 64'h0);
		send_idle = 22;
		recv_stall = 22;
		send_random(80);
		drain_and_settle();
		write_key(REG_KEY_HIGH, {$urandom, $urandom});
		send_idle = 0;
		recv_stall = 0;
		hold_req = 1;
		send_random(90);
		drain_and_settle();
		if (errors == 0) begin
			$display("aes_ctr_cbc_mac_block test passed");
		end else begin
			$display("aes_ctr_cbc_mac_block test failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("aes_ctr_cbc_mac_block test failed");
		$finish;
	end

endmodule
